@@ sv/srb_pkg.sv @@
// shared constants, codes and control types for the sequence reorder buffer
package srb_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_MAX_AGE  = 2'd1;

  localparam logic [5:0]  CAP_RESET = 6'd32;
  localparam logic [15:0] AGE_RESET = 16'd1000;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_LOAD   = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan;
    logic decide;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_full;
  } sts_t;

endpackage

@@ sv/srb_ctrl.sv @@
// request sequencer: accept, table scan, decision, result load
module srb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srb_pkg::sts_t sts_i,
  output srb_pkg::cmd_t cmd_o
);
  import srb_pkg::*;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        if (!sts_i.out_full) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/srb_dpath.sv @@
// table storage, scan compare unit, update logic, counters and result register
module srb_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srb_pkg::cmd_t cmd_i,
  output srb_pkg::sts_t sts_o,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          req_type_i,
  input  logic [31:0]   sequence_number_i,
  input  logic [39:0]   packet_time_ms_i,
  input  logic [39:0]   now_ms_i,
  input  logic [15:0]   packet_handle_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output logic          accepted_o,
  output logic          evicted_o,
  output logic          out_valid_o,
  output logic [31:0]   out_sequence_o,
  output logic [39:0]   out_time_ms_o,
  output logic [15:0]   out_handle_o,
  output logic [31:0]   drop_count_o,
  output logic [31:0]   reorder_count_o
);
  import srb_pkg::*;

  // configuration
  logic [5:0]  cap_q;
  logic [15:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      age_q <= AGE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CAPACITY) cap_q <= cfg_data_i[5:0];
      if (cfg_index_i == CFG_MAX_AGE)  age_q <= cfg_data_i;
    end
  end

  // latched request word
  logic        req_q;
  logic [31:0] seq_q;
  logic [39:0] t_q, now_q;
  logic [15:0] h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_type_i;
      seq_q <= sequence_number_i;
      t_q   <= packet_time_ms_i;
      now_q <= now_ms_i;
      h_q   <= packet_handle_i;
    end
  end

  // table memories and valid bits
  logic [31:0]      seq_mem [DEPTH];
  logic [39:0]      time_mem [DEPTH];
  logic [15:0]      hdl_mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      seq_rd_q;
  logic [39:0]      time_rd_q;
  logic [15:0]      hdl_rd_q;

  // scan pipeline
  logic [CW-1:0] idx_q;
  logic [AW-1:0] rd_addr;
  logic          pe_q, pv_q;
  logic [AW-1:0] pi_q;
  logic          in_range;

  // scan results
  logic          dup_f_q, free_f_q, min_f_q;
  logic [AW-1:0] dup_i_q, free_i_q, min_i_q;
  logic [31:0]   min_seq_q;
  logic [CW-1:0] cnt_q;

  assign rd_addr  = idx_q[AW-1:0];
  assign in_range = (idx_q < CW'(DEPTH));
  assign sts_o.scan_done = (idx_q == CW'(DEPTH)) && !pe_q;

  // write port and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seq_mem[wr_addr]  <= seq_q;
      time_mem[wr_addr] <= t_q;
      hdl_mem[wr_addr]  <= h_q;
    end
    seq_rd_q <= seq_mem[rd_addr];
    if (cmd_i.decide) begin
      time_rd_q <= time_mem[min_i_q];
      hdl_rd_q  <= hdl_mem[min_i_q];
    end
  end

  // scan walk: one entry a cycle, compare one stage behind the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pe_q  <= 1'b0;
    end else if (cmd_i.latch) begin
      idx_q <= '0;
      pe_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      pe_q <= in_range;
      if (in_range) idx_q <= idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= vld_q[rd_addr];
    pi_q <= rd_addr;
    if (cmd_i.latch) begin
      dup_f_q  <= 1'b0;
      free_f_q <= 1'b0;
      min_f_q  <= 1'b0;
      cnt_q    <= '0;
    end else if (cmd_i.scan && pe_q) begin
      if (pv_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (!dup_f_q && seq_rd_q == seq_q) begin
          dup_f_q <= 1'b1;
          dup_i_q <= pi_q;
        end
        if (!min_f_q || seq_rd_q < min_seq_q) begin
          min_f_q   <= 1'b1;
          min_i_q   <= pi_q;
          min_seq_q <= seq_rd_q;
        end
      end else if (!free_f_q) begin
        free_f_q <= 1'b1;
        free_i_q <= pi_q;
      end
    end
  end

  // decision logic
  logic [CW-1:0] lim;
  logic          too_old;
  logic          set_en, clr_en;
  logic [AW-1:0] set_i, clr_i;
  logic          r_acc, r_ev, r_val, drop_inc, take_inc;

  always_comb begin
    if (cap_q == 6'd0) begin
      lim = CW'(1);
    end else if (int'(cap_q) > int'(DEPTH)) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(cap_q);
    end
    too_old  = ({1'b0, t_q} + {25'd0, age_q}) < {1'b0, now_q};
    wr_en    = 1'b0;
    wr_addr  = free_i_q;
    set_en   = 1'b0;
    set_i    = free_i_q;
    clr_en   = 1'b0;
    clr_i    = min_i_q;
    r_acc    = 1'b0;
    r_ev     = 1'b0;
    r_val    = 1'b0;
    drop_inc = 1'b0;
    take_inc = 1'b0;
    if (req_q == REQ_ADD) begin
      if (too_old) begin
        drop_inc = 1'b1;
      end else begin
        r_acc = 1'b1;
        if (dup_f_q) begin
          wr_en   = 1'b1;
          wr_addr = dup_i_q;
          if (cnt_q > lim) begin
            clr_en   = 1'b1;
            r_ev     = 1'b1;
            drop_inc = 1'b1;
          end
        end else if (free_f_q) begin
          wr_en = 1'b1;
          if ((cnt_q + CW'(1)) > lim) begin
            r_ev     = 1'b1;
            drop_inc = 1'b1;
            // new word leaves at once if it is the smallest, else the held smallest goes
            if (min_f_q && !(seq_q < min_seq_q)) begin
              set_en = 1'b1;
              clr_en = 1'b1;
            end
          end else begin
            set_en = 1'b1;
          end
        end else begin
          // table full: smallest of held and new is dropped
          r_ev     = 1'b1;
          drop_inc = 1'b1;
          if (min_f_q && min_seq_q < seq_q) begin
            wr_en   = 1'b1;
            wr_addr = min_i_q;
          end
        end
      end
    end else if (min_f_q) begin
      r_val    = 1'b1;
      take_inc = 1'b1;
      clr_en   = 1'b1;
    end
    if (!cmd_i.decide) begin
      wr_en = 1'b0;
    end
  end

  // valid bits, counters, pending result fields
  logic [31:0] drop_q, take_q;
  logic        r_acc_q, r_ev_q, r_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      drop_q <= '0;
      take_q <= '0;
    end else if (cmd_i.decide) begin
      if (set_en) vld_q[set_i] <= 1'b1;
      if (clr_en) vld_q[clr_i] <= 1'b0;
      if (drop_inc) drop_q <= drop_q + 32'd1;
      if (take_inc) take_q <= take_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      r_acc_q <= r_acc;
      r_ev_q  <= r_ev;
      r_val_q <= r_val;
    end
  end

  // output register
  logic rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      accepted_o      <= r_acc_q;
      evicted_o       <= r_ev_q;
      out_valid_o     <= r_val_q;
      out_sequence_o  <= r_val_q ? min_seq_q : 32'd0;
      out_time_ms_o   <= r_val_q ? time_rd_q : 40'd0;
      out_handle_o    <= r_val_q ? hdl_rd_q : 16'd0;
      drop_count_o    <= drop_q;
      reorder_count_o <= take_q;
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign sts_o.out_full = rsp_valid_q && !rsp_ready_i;

endmodule

@@ sv/sequence_reorder_buffer_core.sv @@
// top level of the sequence reorder buffer
// Reorder table of 32 packet descriptors kept by sequence number. An add word
// is dropped if packet_time_ms plus the configured maximum age is below now_ms,
// else it is stored (a duplicate sequence overwrites) and the smallest sequence
// is evicted when the count exceeds capacity_limit; a take word removes and
// returns the smallest-sequence entry. One request is in work at a time: every
// request walks the whole table through the single read port of the sequence
// memory, one entry a cycle, then passes a decide state for the update and a
// load state that fills the result register, stalling while the output is full.
// The result register lets a new request be accepted while the previous result
// waits. Configuration is always ready and takes effect at once.
module sequence_reorder_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] sequence_number_i,
  input  logic [39:0] packet_time_ms_i,
  input  logic [39:0] now_ms_i,
  input  logic [15:0] packet_handle_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output logic        accepted_o,
  output logic        evicted_o,
  output logic        out_valid_o,
  output logic [31:0] out_sequence_o,
  output logic [39:0] out_time_ms_o,
  output logic [15:0] out_handle_o,
  output logic [31:0] drop_count_o,
  output logic [31:0] reorder_count_o
);
  import srb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  srb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and result path
  srb_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .req_type_i        (req_type_i),
    .sequence_number_i (sequence_number_i),
    .packet_time_ms_i  (packet_time_ms_i),
    .now_ms_i          (now_ms_i),
    .packet_handle_i   (packet_handle_i),
    .rsp_valid_o       (rsp_valid_o),
    .rsp_ready_i       (rsp_ready_i),
    .accepted_o        (accepted_o),
    .evicted_o         (evicted_o),
    .out_valid_o       (out_valid_o),
    .out_sequence_o    (out_sequence_o),
    .out_time_ms_o     (out_time_ms_o),
    .out_handle_o      (out_handle_o),
    .drop_count_o      (drop_count_o),
    .reorder_count_o   (reorder_count_o)
  );

endmodule
